FILE: hw/rtl/ssi_pkg.sv
// Shared types and constants for the segment intersection core.
// No dependencies; imported by ssi_div, segment_segment_intersection_core and the checker.
package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    typedef logic [1:0] t_rel;

    localparam t_rel REL_NONE      = 2'd0;
    localparam t_rel REL_INTERSECT = 2'd1;
    localparam t_rel REL_CONTAIN   = 2'd2;

endpackage

FILE: hw/rtl/ssi_div.sv
// Pipelined restoring divider for two unsigned numerators over a shared divisor.
// One quotient bit per stage; depends on ssi_pkg.
module ssi_div #(
    parameter int NW = 52,
    parameter int PW = 35,
    parameter int QW = 17,
    parameter int SW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num_a,
    input  logic [NW-1:0] i_num_b,
    input  logic [PW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quo_a,
    output logic [QW-1:0] o_quo_b,
    output logic [SW-1:0] o_side
);
    import ssi_pkg::*;

    // Entry 0 is the incoming item, entry k+1 the register after stage k.
    logic          s_v    [0:QW];
    logic          s_rdy  [0:QW];
    logic [NW-1:0] s_rem_a[0:QW];
    logic [NW-1:0] s_rem_b[0:QW];
    logic [PW-1:0] s_den  [0:QW];
    logic [QW-1:0] s_q_a  [0:QW];
    logic [QW-1:0] s_q_b  [0:QW];
    logic [SW-1:0] s_side [0:QW];

    assign s_v[0]     = i_valid;
    assign s_rem_a[0] = i_num_a;
    assign s_rem_b[0] = i_num_b;
    assign s_den[0]   = i_den;
    assign s_q_a[0]   = '0;
    assign s_q_b[0]   = '0;
    assign s_side[0]  = i_side;
    assign s_rdy[QW]  = i_ready;
    assign o_ready    = s_rdy[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] w_shift;
        logic          w_ge_a;
        logic          w_ge_b;

        assign s_rdy[k] = !s_v[k+1] || s_rdy[k+1];
        assign w_shift  = NW'(s_den[k]) << (QW - 1 - k);
        assign w_ge_a   = s_rem_a[k] >= w_shift;
        assign w_ge_b   = s_rem_b[k] >= w_shift;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else if (s_rdy[k]) begin
                s_v[k+1] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_rdy[k] && s_v[k]) begin
                s_rem_a[k+1] <= w_ge_a ? s_rem_a[k] - w_shift : s_rem_a[k];
                s_rem_b[k+1] <= w_ge_b ? s_rem_b[k] - w_shift : s_rem_b[k];
                s_q_a[k+1]   <= s_q_a[k] | (QW'(w_ge_a) << (QW - 1 - k));
                s_q_b[k+1]   <= s_q_b[k] | (QW'(w_ge_b) << (QW - 1 - k));
                s_den[k+1]   <= s_den[k];
                s_side[k+1]  <= s_side[k];
            end
        end
    end

    assign o_valid = s_v[QW];
    assign o_quo_a = s_q_a[QW];
    assign o_quo_b = s_q_b[QW];
    assign o_side  = s_side[QW];

`ifndef NO_ASSERTIONS
    // A blocked output stage must hold its item.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("divider dropped a stalled item");
    // The input can only be refused while the first stage is occupied.
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> s_v[1])
        else $error("divider refused an item with an empty first stage");
    // A stalled output item keeps its quotients and side data.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            ($stable(o_quo_a) && $stable(o_quo_b) && $stable(o_side)))
        else $error("divider changed a stalled item");
`endif

endmodule

FILE: hw/rtl/segment_segment_intersection_core.sv
// Segment intersection core: two 2D segments in, relation and hit point out.
// Depends on ssi_pkg and ssi_div.
//
// Usage: the slave channel takes one segment pair per item in i_s_tdata,
// packed from the lowest bit: first_start_x, first_start_y, first_stop_x,
// first_stop_y, second_start_x, second_start_y, second_stop_x, second_stop_y,
// each COORD_WIDTH bits signed. The master channel returns one item per pair:
// relation (2 bits), hit_x, hit_y (COORD_WIDTH bits each), hit_valid (1 bit).
// The pipeline has five arithmetic stages, one divider stage per quotient bit,
// and the output register. The divider that forms the hit point sets the
// depth; a new item is accepted every cycle unless the pipeline is stalled.
// Each stage holds its item while the next stage is full, so a stall on
// i_m_tready backs up through the pipeline without losing items, and empty
// stages still fill while the output is blocked.
// A synchronous reset on i_rst_n empties all stages; no item is pending
// afterwards. The block has no state beyond the items in flight.
module segment_segment_intersection_core #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // first_start_x, first_start_y, first_stop_x, first_stop_y,
    // second_start_x, second_start_y, second_stop_x, second_stop_y
    input  logic [8*COORD_WIDTH-1:0]             i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // relation, hit_x, hit_y, hit_valid, zero fill
    output logic [((2*COORD_WIDTH+3+7)/8)*8-1:0] o_m_tdata
);
    import ssi_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW + 1;
    localparam int NW = DW + PW;
    localparam int QW = DW;
    localparam int SW = 5 + 2 * CW;
    localparam int OW = ((2 * CW + 3 + 7) / 8) * 8;

    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_dx, w_dy;
    assign w_ax = i_s_tdata[0*CW +: CW];
    assign w_ay = i_s_tdata[1*CW +: CW];
    assign w_bx = i_s_tdata[2*CW +: CW];
    assign w_by = i_s_tdata[3*CW +: CW];
    assign w_cx = i_s_tdata[4*CW +: CW];
    assign w_cy = i_s_tdata[5*CW +: CW];
    assign w_dx = i_s_tdata[6*CW +: CW];
    assign w_dy = i_s_tdata[7*CW +: CW];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy_div, w_rdy_out;

    // Stage 1: direction vectors and the parallel-case box test.
    logic signed [DW-1:0] r1_d1x, r1_d1y, r1_d2x, r1_d2y, r1_ox, r1_oy;
    logic signed [CW-1:0] r1_ax, r1_ay;
    t_rel                 r1_par, n1_par;

    always_comb begin
        if (w_ax <= w_cx && w_ay <= w_cy && w_bx >= w_dx && w_by >= w_dy) begin
            n1_par = REL_CONTAIN;
        end else if (w_ax <= w_cx && w_bx >= w_cx) begin
            n1_par = REL_INTERSECT;
        end else begin
            n1_par = REL_NONE;
        end
    end

    // Stage 2: cross products.
    logic signed [2*DW-1:0] r2_pda, r2_pdb, r2_pta, r2_ptb, r2_psa, r2_psb;
    logic signed [DW-1:0]   r2_d1x, r2_d1y;
    logic signed [CW-1:0]   r2_ax, r2_ay;
    t_rel                   r2_par;

    // Stage 3: denominator and the two numerators.
    logic signed [PW-1:0] r3_den, r3_tn, r3_sn;
    logic signed [DW-1:0] r3_d1x, r3_d1y;
    logic signed [CW-1:0] r3_ax, r3_ay;
    t_rel                 r3_par;

    // Stage 4: range tests and scaled offsets.
    logic signed [NW-1:0] r4_mx, r4_my;
    logic signed [PW-1:0] r4_den;
    logic signed [CW-1:0] r4_ax, r4_ay;
    t_rel                 r4_rel, n4_rel;
    logic                 r4_hit, n4_hit;
    logic                 w_t_in, w_s_in;

    always_comb begin
        if (r3_den > 0) begin
            w_t_in = r3_tn >= 0 && r3_tn <= r3_den;
            w_s_in = r3_sn >= 0 && r3_sn <= r3_den;
        end else begin
            w_t_in = r3_tn <= 0 && r3_tn >= r3_den;
            w_s_in = r3_sn <= 0 && r3_sn >= r3_den;
        end
        n4_hit = (r3_den != '0) && w_t_in && w_s_in;
        if (r3_den == '0) begin
            n4_rel = r3_par;
        end else begin
            n4_rel = n4_hit ? REL_INTERSECT : REL_NONE;
        end
    end

    // Stage 5: magnitudes and quotient signs for the divider.
    logic [NW-1:0]        r5_mag_x, r5_mag_y;
    logic [PW-1:0]        r5_mag_d;
    logic                 r5_neg_x, r5_neg_y;
    logic signed [CW-1:0] r5_ax, r5_ay;
    t_rel                 r5_rel;
    logic                 r5_hit;

    assign w_rdy_out = !r_ov || i_m_tready;
    assign w_rdy5    = !r_v5 || w_rdy_div;
    assign w_rdy4    = !r_v4 || w_rdy5;
    assign w_rdy3    = !r_v3 || w_rdy4;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_tvalid) begin
            r1_d1x <= DW'(w_bx) - DW'(w_ax);
            r1_d1y <= DW'(w_by) - DW'(w_ay);
            r1_d2x <= DW'(w_dx) - DW'(w_cx);
            r1_d2y <= DW'(w_dy) - DW'(w_cy);
            r1_ox  <= DW'(w_ax) - DW'(w_cx);
            r1_oy  <= DW'(w_ay) - DW'(w_cy);
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_par <= n1_par;
        end
        if (w_rdy2 && r_v1) begin
            r2_pda <= (2*DW)'(r1_d2y) * (2*DW)'(r1_d1x);
            r2_pdb <= (2*DW)'(r1_d2x) * (2*DW)'(r1_d1y);
            r2_pta <= (2*DW)'(r1_d2x) * (2*DW)'(r1_oy);
            r2_ptb <= (2*DW)'(r1_d2y) * (2*DW)'(r1_ox);
            r2_psa <= (2*DW)'(r1_d1x) * (2*DW)'(r1_oy);
            r2_psb <= (2*DW)'(r1_d1y) * (2*DW)'(r1_ox);
            r2_d1x <= r1_d1x;
            r2_d1y <= r1_d1y;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_par <= r1_par;
        end
        if (w_rdy3 && r_v2) begin
            r3_den <= PW'(r2_pda) - PW'(r2_pdb);
            r3_tn  <= PW'(r2_pta) - PW'(r2_ptb);
            r3_sn  <= PW'(r2_psa) - PW'(r2_psb);
            r3_d1x <= r2_d1x;
            r3_d1y <= r2_d1y;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_par <= r2_par;
        end
        if (w_rdy4 && r_v3) begin
            r4_mx  <= NW'(r3_d1x) * NW'(r3_tn);
            r4_my  <= NW'(r3_d1y) * NW'(r3_tn);
            r4_den <= r3_den;
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_rel <= n4_rel;
            r4_hit <= n4_hit;
        end
        if (w_rdy5 && r_v4) begin
            r5_mag_x <= r4_mx[NW-1] ? NW'(-r4_mx) : NW'(r4_mx);
            r5_mag_y <= r4_my[NW-1] ? NW'(-r4_my) : NW'(r4_my);
            r5_mag_d <= r4_den[PW-1] ? PW'(-r4_den) : PW'(r4_den);
            r5_neg_x <= r4_mx[NW-1] ^ r4_den[PW-1];
            r5_neg_y <= r4_my[NW-1] ^ r4_den[PW-1];
            r5_ax    <= r4_ax;
            r5_ay    <= r4_ay;
            r5_rel   <= r4_rel;
            r5_hit   <= r4_hit;
        end
    end

    logic          w_dv;
    logic [QW-1:0] w_qx, w_qy;
    logic [SW-1:0] w_side_in, w_side_out;

    assign w_side_in = {r5_ay, r5_ax, r5_neg_y, r5_neg_x, r5_hit, r5_rel};

    ssi_div #(
        .NW(NW),
        .PW(PW),
        .QW(QW),
        .SW(SW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_v5),
        .o_ready(w_rdy_div),
        .i_num_a(r5_mag_x),
        .i_num_b(r5_mag_y),
        .i_den  (r5_mag_d),
        .i_side (w_side_in),
        .o_valid(w_dv),
        .i_ready(w_rdy_out),
        .o_quo_a(w_qx),
        .o_quo_b(w_qy),
        .o_side (w_side_out)
    );

    // Output stage: signed offset added to the start of segment one.
    t_rel                 w_rel;
    logic                 w_hit, w_neg_x, w_neg_y;
    logic signed [CW-1:0] w_oax, w_oay;
    logic signed [DW:0]   w_offx, w_offy, w_px, w_py;

    assign w_rel   = w_side_out[1:0];
    assign w_hit   = w_side_out[2];
    assign w_neg_x = w_side_out[3];
    assign w_neg_y = w_side_out[4];
    assign w_oax   = w_side_out[5 +: CW];
    assign w_oay   = w_side_out[5+CW +: CW];
    assign w_offx  = w_neg_x ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_offy  = w_neg_y ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    assign w_px    = (DW+1)'(w_oax) + w_offx;
    assign w_py    = (DW+1)'(w_oay) + w_offy;

    t_rel          r_rel;
    logic [CW-1:0] r_hx, r_hy;
    logic          r_hv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy_out) begin
            r_ov <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && w_dv) begin
            r_rel <= w_rel;
            r_hv  <= w_hit;
            r_hx  <= w_hit ? w_px[CW-1:0] : '0;
            r_hy  <= w_hit ? w_py[CW-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OW'({r_hv, r_hy, r_hx, r_rel});

`ifndef NO_ASSERTIONS
    // A computed point always comes with an intersect relation.
    a_hit_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_hv) |-> (r_rel == REL_INTERSECT))
        else $error("hit point without intersect relation");
    // No computed point means a zero point.
    a_zero_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_hv) |-> (r_hx == '0 && r_hy == '0))
        else $error("nonzero point without a hit");
    // Input refused only while the first stage holds an item.
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_v1)
        else $error("input refused with an empty first stage");
`endif

endmodule

FILE: tb/segment_segment_intersection_checker.sv
// Checker for the segment intersection core: predicts each result item from
// the accepted input items and compares it with the output channel.
// Depends on ssi_pkg.
`timescale 1ns / 1ps

module segment_segment_intersection_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    import ssi_pkg::*;

    typedef struct packed {
        logic       hit_valid;
        logic [15:0] hit_y;
        logic [15:0] hit_x;
        t_rel       relation;
    } t_hit_result;

    t_hit_result hits_pending[$];
    int mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = hits_pending.size();

    function automatic longint abs_val(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint quot_trunc(longint num, longint den);
        longint q;
        q = abs_val(num) / abs_val(den);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic bit in_unit_range(longint num, longint den);
        if (den > 0) return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic t_hit_result intersect_segments(logic [127:0] seg);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint d1x, d1y, d2x, d2y, ox, oy, den, tn, sn, px, py;
        t_hit_result r;
        ax = longint'($signed(seg[15:0]));    ay = longint'($signed(seg[31:16]));
        bx = longint'($signed(seg[47:32]));   by = longint'($signed(seg[63:48]));
        cx = longint'($signed(seg[79:64]));   cy = longint'($signed(seg[95:80]));
        dx = longint'($signed(seg[111:96]));  dy = longint'($signed(seg[127:112]));
        d1x = bx - ax; d1y = by - ay; d2x = dx - cx; d2y = dy - cy;
        ox = ax - cx;  oy = ay - cy;
        den = d2y * d1x - d2x * d1y;
        r = '0;
        r.relation = REL_NONE;
        if (den == 0) begin
            if (ax <= cx && ay <= cy && bx >= dx && by >= dy)
                r.relation = REL_CONTAIN;
            else if (ax <= cx && bx >= cx)
                r.relation = REL_INTERSECT;
        end else begin
            tn = d2x * oy - d2y * ox;
            sn = d1x * oy - d1y * ox;
            if (in_unit_range(tn, den) && in_unit_range(sn, den)) begin
                px = ax + quot_trunc(d1x * tn, den);
                py = ay + quot_trunc(d1y * tn, den);
                r.relation  = REL_INTERSECT;
                r.hit_x     = px[15:0];
                r.hit_y     = py[15:0];
                r.hit_valid = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hit_result want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                hits_pending.push_back(intersect_segments(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[34:0];
                if (hits_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", got);
                end else begin
                    want = hits_pending.pop_front();
                    if (got !== want || i_m_tdata[39:35] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: rel %0d/%0d x %h/%h y %h/%h v %b/%b",
                                want.relation, got.relation, want.hit_x, got.hit_x,
                                want.hit_y, got.hit_y, want.hit_valid, got.hit_valid);
                    end
                end
            end
        end
    end
endmodule

FILE: tb/segment_segment_intersection_core_test.sv
// Top of the segment intersection testbench: clock, reset, stimulus, verdict.
// Depends on ssi_pkg, segment_segment_intersection_core and the checker.
`timescale 1ns / 1ps

module segment_segment_intersection_core_test;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    int           fail_count, pending;
    int           send_idle = 0, recv_stall = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    segment_segment_intersection_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    segment_segment_intersection_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random with the percentage of the current phase.
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    function automatic logic [15:0] pick_coord(int span);
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    // Shapes favor real crossings, parallels and containment over pure noise.
    function automatic logic [127:0] random_pair();
        logic [15:0] p[8];
        logic [15:0] k;
        int span;
        span = $urandom_range(3) == 0 ? 32767 : 400;
        for (int i = 0; i < 8; i++) p[i] = pick_coord(span);
        case ($urandom_range(5))
            0: begin
                // Segment two parallel to segment one, shifted.
                k = 16'($urandom_range(20));
                p[4] = p[0] + k; p[5] = p[1] + k;
                p[6] = p[2] + k; p[7] = p[3] + k;
            end
            1: begin
                // Segment two inside segment one on the same line.
                p[4] = p[0]; p[5] = p[1]; p[6] = p[2]; p[7] = p[3];
            end
            2: begin
                // Crossing diagonals of a parallelogram.
                p[6] = p[0] + p[2] - p[4]; p[7] = p[1] + p[3] - p[5];
            end
            default: ;
        endcase
        return {p[7], p[6], p[5], p[4], p[3], p[2], p[1], p[0]};
    endfunction

    // The valid line drops only during idle cycles, so items can follow back to back.
    task automatic send_pair(logic [127:0] seg);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= seg;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int idle_pct[4] = '{0, 64, 0, 11};
        int stall_pct[4] = '{0, 0, 64, 11};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: extremes, crossings, parallel cases, endpoint touches.
        send_pair('0);
        send_pair({8{16'h8000}});
        send_pair({8{16'h7fff}});
        send_pair({8{16'hffff}});
        send_pair({16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                   16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        send_pair({16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                   16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
        send_pair({16'd40, 16'd0, 16'd0, 16'd40, 16'd40, 16'd40, 16'd0, 16'd0});
        send_pair({16'd30, 16'd30, 16'd10, 16'd10, 16'd40, 16'd40, 16'd0, 16'd0});
        send_pair({16'd50, 16'd50, 16'd10, 16'd10, 16'd40, 16'd40, 16'd0, 16'd0});
        send_pair({16'd60, 16'd60, 16'd50, 16'd50, 16'd40, 16'd40, 16'd0, 16'd0});
        send_pair({16'd5, 16'd40, 16'd5, 16'd0, 16'd0, 16'd40, 16'd0, 16'd0});
        send_pair({16'd40, 16'd20, 16'd0, 16'd20, 16'd0, 16'd40, 16'd0, 16'd0});
        send_pair({16'd40, 16'd50, 16'd0, 16'd50, 16'd0, 16'd40, 16'd0, 16'd0});
        send_pair({16'd3, 16'd7, 16'd0, 16'd0, 16'd0, 16'd5, 16'd7, 16'd1});
        send_pair({16'hffd8, 16'h0028, 16'h0028, 16'hffd8,
                   16'h0028, 16'h0028, 16'hffd8, 16'hffd8});
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = idle_pct[ph];
            recv_stall = stall_pct[ph];
            for (int n = 0; n < 385; n++) send_pair(random_pair());
        end
        s_tvalid <= 1'b0;
        recv_stall = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
